// ===== sv/rihc_pkg.sv =====
package rihc_pkg;

  // Table geometry and field widths
  localparam int SLOT_COUNT = 16;
  localparam int POS_W      = 5;
  localparam int TIME_W     = 18;
  localparam int WIN_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 18;

  localparam logic [POS_W-1:0]  SLOT_LAST = POS_W'(SLOT_COUNT);
  localparam logic [POS_W-1:0]  SLOT_HOME = POS_W'(1);
  localparam logic [TIME_W-1:0] T_MAX     = {TIME_W{1'b1}};

  // Operation codes
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_GOTO = 1'b1;

  // Phase codes
  localparam logic [2:0] PH_IDLE     = 3'd0;
  localparam logic [2:0] PH_HOMING   = 3'd1;
  localparam logic [2:0] PH_STEPPING = 3'd2;
  localparam logic [2:0] PH_OVERRUN  = 3'd3;
  localparam logic [2:0] PH_BACKOFF  = 3'd4;

  // Motor drive codes
  localparam logic [1:0] MOTOR_STOP    = 2'd0;
  localparam logic [1:0] MOTOR_FORWARD = 2'd1;
  localparam logic [1:0] MOTOR_REVERSE = 2'd2;

  // Status codes
  localparam logic [2:0] ST_NONE       = 3'd0;
  localparam logic [2:0] ST_REACHED    = 3'd1;
  localparam logic [2:0] ST_HOME_FAIL  = 3'd2;
  localparam logic [2:0] ST_STEP_FAIL  = 3'd3;
  localparam logic [2:0] ST_REJECTED   = 3'd4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HOME_LIMIT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_LIMIT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAIR_WIN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_MIN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_OVERRUN    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BACKOFF    = 3'd5;

  // Configuration reset values
  localparam logic [TIME_W-1:0] RST_HOME_LIMIT = TIME_W'(120000);
  localparam logic [TIME_W-1:0] RST_STEP_LIMIT = TIME_W'(30000);
  localparam logic [WIN_W-1:0]  RST_PAIR_WIN   = WIN_W'(2000);
  localparam logic [WIN_W-1:0]  RST_STEP_MIN   = WIN_W'(2000);
  localparam logic [WIN_W-1:0]  RST_OVERRUN    = WIN_W'(700);
  localparam logic [WIN_W-1:0]  RST_BACKOFF    = WIN_W'(200);

  typedef struct packed {
    logic [TIME_W-1:0] home_limit;
    logic [TIME_W-1:0] step_limit;
    logic [WIN_W-1:0]  pair_win;
    logic [WIN_W-1:0]  step_min;
    logic [WIN_W-1:0]  overrun;
    logic [WIN_W-1:0]  backoff;
  } cfg_t;

  typedef struct packed {
    logic [1:0]       motor_drive;
    logic [POS_W-1:0] position;
    logic             busy_res;
    logic [2:0]       status;
  } result_t;

endpackage

// ===== sv/rihc_cfg.sv =====
module rihc_cfg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rihc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rihc_pkg::CFG_DATA_W-1:0]     cfg_data,
  output rihc_pkg::cfg_t                      cfg
);
  import rihc_pkg::*;

  assign cfg_ready = 1'b1;

  // Load defaults on reset, take one register per write transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.home_limit <= RST_HOME_LIMIT;
      cfg.step_limit <= RST_STEP_LIMIT;
      cfg.pair_win   <= RST_PAIR_WIN;
      cfg.step_min   <= RST_STEP_MIN;
      cfg.overrun    <= RST_OVERRUN;
      cfg.backoff    <= RST_BACKOFF;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_HOME_LIMIT: cfg.home_limit <= cfg_data[TIME_W-1:0];
        CFG_STEP_LIMIT: cfg.step_limit <= cfg_data[TIME_W-1:0];
        CFG_PAIR_WIN:   cfg.pair_win   <= cfg_data[WIN_W-1:0];
        CFG_STEP_MIN:   cfg.step_min   <= cfg_data[WIN_W-1:0];
        CFG_OVERRUN:    cfg.overrun    <= cfg_data[WIN_W-1:0];
        CFG_BACKOFF:    cfg.backoff    <= cfg_data[WIN_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== sv/rihc_core.sv =====
module rihc_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          fire,
  input  logic                          op,
  input  logic                          sensor,
  input  logic [rihc_pkg::POS_W-1:0]    target,
  input  rihc_pkg::cfg_t                cfg,
  output rihc_pkg::result_t             res
);
  import rihc_pkg::*;

  logic [2:0]        phase, phase_next;
  logic [POS_W-1:0]  slot_position, slot_position_next;
  logic [POS_W-1:0]  goal_slot, goal_slot_next;
  logic [TIME_W-1:0] elapsed_ms, elapsed_ms_next;
  logic [TIME_W-1:0] last_edge_ms, last_edge_ms_next;
  logic              last_edge_seen, last_edge_seen_next;
  logic              previous_sensor, previous_sensor_next;

  logic              rising;
  logic [TIME_W:0]   tick_count;
  logic [TIME_W-1:0] tick_sat;
  logic [TIME_W-1:0] edge_gap;
  logic              bad_target;
  logic [POS_W-1:0]  slot_after;
  logic [2:0]        status;

  assign rising     = !previous_sensor && sensor;
  assign tick_count = {1'b0, elapsed_ms} + (TIME_W+1)'(1);
  assign tick_sat   = (tick_count > {1'b0, T_MAX}) ? T_MAX : tick_count[TIME_W-1:0];
  assign edge_gap   = tick_sat - last_edge_ms;
  assign bad_target = (target == '0) || (target > SLOT_LAST);
  assign slot_after = (slot_position >= SLOT_LAST) ? SLOT_HOME
                                                   : slot_position + POS_W'(1);

  // Work out the state after one item
  always_comb begin
    phase_next           = phase;
    slot_position_next   = slot_position;
    goal_slot_next       = goal_slot;
    elapsed_ms_next      = elapsed_ms;
    last_edge_ms_next    = last_edge_ms;
    last_edge_seen_next  = last_edge_seen;
    previous_sensor_next = previous_sensor;
    status               = ST_NONE;

    if (op == OP_GOTO) begin
      if (bad_target || phase != PH_IDLE) begin
        status = ST_REJECTED;
      end else if (slot_position == target) begin
        previous_sensor_next = sensor;
        status               = ST_REACHED;
      end else begin
        goal_slot_next       = target;
        previous_sensor_next = sensor;
        elapsed_ms_next      = '0;
        if (slot_position == '0) begin
          phase_next          = PH_HOMING;
          last_edge_ms_next   = '0;
          last_edge_seen_next = sensor;
        end else begin
          phase_next = PH_STEPPING;
        end
      end
    end else begin
      previous_sensor_next = sensor;
      if (phase != PH_IDLE) begin
        elapsed_ms_next = tick_sat;
      end
      unique case (phase)
        PH_HOMING: begin
          if (tick_count > {1'b0, cfg.home_limit}) begin
            phase_next      = PH_IDLE;
            elapsed_ms_next = '0;
            status          = ST_HOME_FAIL;
          end else if (rising) begin
            if (last_edge_seen && edge_gap <= TIME_W'(cfg.pair_win)) begin
              slot_position_next = SLOT_HOME;
              phase_next         = PH_BACKOFF;
              elapsed_ms_next    = '0;
            end else begin
              last_edge_ms_next   = tick_sat;
              last_edge_seen_next = 1'b1;
            end
          end
        end
        PH_STEPPING: begin
          if (tick_count > {1'b0, cfg.step_limit}) begin
            phase_next      = PH_IDLE;
            elapsed_ms_next = '0;
            status          = ST_STEP_FAIL;
          end else if (rising && tick_sat > TIME_W'(cfg.step_min)) begin
            slot_position_next = slot_after;
            phase_next         = PH_OVERRUN;
            elapsed_ms_next    = '0;
          end
        end
        PH_OVERRUN: begin
          if (tick_sat >= TIME_W'(cfg.overrun)) begin
            phase_next      = PH_BACKOFF;
            elapsed_ms_next = '0;
          end
        end
        PH_BACKOFF: begin
          if (tick_sat >= TIME_W'(cfg.backoff)) begin
            elapsed_ms_next = '0;
            if (slot_position == goal_slot) begin
              phase_next = PH_IDLE;
              status     = ST_REACHED;
            end else begin
              phase_next = PH_STEPPING;
            end
          end
        end
        default: begin
          phase_next      = PH_IDLE;
          elapsed_ms_next = '0;
        end
      endcase
    end
  end

  // Drive result fields from the new phase, position and status
  always_comb begin
    priority if (phase_next == PH_HOMING || phase_next == PH_STEPPING ||
                 phase_next == PH_OVERRUN) begin
      res.motor_drive = MOTOR_FORWARD;
    end else if (phase_next == PH_BACKOFF) begin
      res.motor_drive = MOTOR_REVERSE;
    end else begin
      res.motor_drive = MOTOR_STOP;
    end
    res.position = slot_position_next;
    res.busy_res = (phase_next != PH_IDLE);
    res.status   = status;
  end

  // Commit state once per transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      slot_position   <= '0;
      goal_slot       <= '0;
      elapsed_ms      <= '0;
      last_edge_ms    <= '0;
      last_edge_seen  <= 1'b0;
      previous_sensor <= 1'b0;
    end else if (fire) begin
      phase           <= phase_next;
      slot_position   <= slot_position_next;
      goal_slot       <= goal_slot_next;
      elapsed_ms      <= elapsed_ms_next;
      last_edge_ms    <= last_edge_ms_next;
      last_edge_seen  <= last_edge_seen_next;
      previous_sensor <= previous_sensor_next;
    end
  end

  a_phase_legal: assert property (@(posedge clk) disable iff (rst)
    phase <= PH_BACKOFF)
    else $error("phase left the legal range");

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    slot_position <= SLOT_LAST)
    else $error("position beyond last slot");

  a_idle_clock: assert property (@(posedge clk) disable iff (rst)
    phase == PH_IDLE |-> elapsed_ms == '0)
    else $error("elapsed time running while idle");

  a_goal_set: assert property (@(posedge clk) disable iff (rst)
    phase != PH_IDLE |-> (goal_slot != '0 && goal_slot <= SLOT_LAST))
    else $error("moving without a valid goal slot");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !fire |=> $stable(phase) && $stable(slot_position))
    else $error("state changed without a transaction");

endmodule

// ===== sv/rotary_indexer_homing_control.sv =====
// An accepted item passes the input register, then the result register,
// before its result is offered. The result register frees as it is taken.
// Throughput: one item per cycle unless out_stall holds a waiting result.
// Reset (rst, synchronous, active high): phase idle, position unknown,
// registers at their defaults, both pipeline stages empty.
module rotary_indexer_homing_control (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              op,
  input  logic                              sensor,
  input  logic [rihc_pkg::POS_W-1:0]        target,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [1:0]                        motor_drive,
  output logic [rihc_pkg::POS_W-1:0]        position,
  output logic                              busy_res,
  output logic [2:0]                        status,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rihc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rihc_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import rihc_pkg::*;

  cfg_t             cfg;
  result_t          res;
  logic             s1_valid;
  logic             s1_op;
  logic             s1_sensor;
  logic [POS_W-1:0] s1_target;
  logic             advance;
  logic             fire;

  assign advance  = !out_valid || !out_stall;
  assign fire     = s1_valid && advance;
  assign in_stall = s1_valid && !advance;

  rihc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  rihc_core u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .op     (s1_op),
    .sensor (s1_sensor),
    .target (s1_target),
    .cfg    (cfg),
    .res    (res)
  );

  // Input register: take a transaction whenever not stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_op     <= op;
      s1_sensor <= sensor;
      s1_target <= target;
    end
  end

  // Result register: hold while stalled, refill from the core
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      motor_drive <= res.motor_drive;
      position    <= res.position;
      busy_res    <= res.busy_res;
      status      <= res.status;
    end
  end

endmodule
